// File: design/nbr_pkg.sv
// Shared types, constants and codes for the navigation bitmap rasterizer.
`timescale 1ns / 1ps
package nbr_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_DEPTH  = 256;
  localparam int LINE_BYTES = (MAX_WIDTH + 7) / 8;
  localparam int H_DEPTH    = MAX_WIDTH * MAX_DEPTH;
  localparam int W_DEPTH    = LINE_BYTES * MAX_DEPTH;
  localparam int HA         = $clog2(H_DEPTH);
  localparam int WA         = $clog2(W_DEPTH);
  localparam int MAX_DIM    = (MAX_WIDTH > MAX_DEPTH) ? MAX_WIDTH : MAX_DEPTH;
  // coordinate width: holds any in-grid value and the exclusive bound
  localparam int CW         = ($clog2(MAX_DIM + 1) > 9) ? $clog2(MAX_DIM + 1) : 9;
  localparam int SW         = 18;

  localparam int WALK_MIN   = 127;
  localparam int WALK_MAX   = 129;
  localparam int HEIGHT_TOP = 255;
  localparam int BIT_MASK   = 7;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_BOX   = 3'd1;
  localparam logic [2:0] OP_BUILD = 3'd2;
  localparam logic [2:0] OP_BLIT  = 3'd3;
  localparam logic [2:0] OP_QUERY = 3'd4;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_DEPTH  = 2'd1;
  localparam logic [1:0] CFG_EXTEND = 2'd2;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [15:0] x_low;
    logic signed [15:0] x_high;
    logic signed [15:0] z_low;
    logic signed [15:0] z_high;
    logic signed [15:0] y_low;
    logic signed [15:0] y_high;
    logic               fill_value;
  } req_t;

  typedef struct packed {
    logic walkable;
    logic op_done;
  } res_t;

  typedef struct packed {
    logic [CW-1:0] x_lo;
    logic [CW-1:0] x_hi;
    logic [CW-1:0] z_lo;
    logic [CW-1:0] z_hi;
    logic [7:0]    top;
    logic          box_hit;
    logic          empty;
    logic          in_grid;
    logic [CW-1:0] qx;
    logic [CW-1:0] qz;
  } bnd_t;

  typedef struct packed {
    logic          we;
    logic [HA-1:0] waddr;
    logic [7:0]    wdata;
    logic [HA-1:0] raddr;
  } hreq_t;

  typedef struct packed {
    logic          we;
    logic [WA-1:0] waddr;
    logic [7:0]    wdata;
    logic [WA-1:0] raddr;
  } wreq_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SETUP, S_CLEAR, S_BOX_RD, S_BOX_WR, S_BUILD,
    S_BUILD_END, S_BLIT_RD, S_BLIT_WR, S_QUERY_RD, S_QUERY_WAIT, S_DONE
  } state_t;

endpackage

// File: design/nbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module nbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/nbr_bounds.sv
// Bounds unit: extends, clamps and clips a request's box or rectangle, and checks a query cell against the grid.
`timescale 1ns / 1ps
module nbr_bounds import nbr_pkg::*; (
  input  req_t          req,
  input  logic [CW-1:0] w_eff,
  input  logic [CW-1:0] d_eff,
  input  logic [7:0]    extend,
  output bnd_t          bnd
);

  localparam logic signed [SW-1:0] TOP_S = SW'(HEIGHT_TOP);

  logic signed [SW-1:0] x0, x1, z0, z1, y0, y1, ws, ds, es;
  logic signed [SW-1:0] xe, ze, xl, zl, xh, zh;

  always_comb begin
    x0 = SW'(req.x_low);
    x1 = SW'(req.x_high);
    z0 = SW'(req.z_low);
    z1 = SW'(req.z_high);
    y0 = SW'(req.y_low);
    y1 = SW'(req.y_high);
    ws = $signed(SW'(w_eff));
    ds = $signed(SW'(d_eff));
    es = $signed(SW'(extend));
    xe = x0 - es;
    ze = z0 - es;
    xl = (xe < 0) ? '0 : xe;
    zl = (ze < 0) ? '0 : ze;
    xh = (x1 < ws) ? x1 : ws;
    zh = (z1 < ds) ? z1 : ds;

    bnd.x_lo    = xl[CW-1:0];
    bnd.z_lo    = zl[CW-1:0];
    bnd.x_hi    = xh[CW-1:0];
    bnd.z_hi    = zh[CW-1:0];
    bnd.empty   = (xl >= xh) || (zl >= zh);
    bnd.box_hit = (x0 < ws) && (x1 > 0) && (z0 < ds) && (z1 > 0) &&
                  (y0 < TOP_S) && (y1 > 0);
    bnd.top     = (y1 > TOP_S) ? 8'(HEIGHT_TOP) : y1[7:0];
    bnd.in_grid = (x0 >= 0) && (z0 >= 0) && (x0 < ws) && (z0 < ds);
    bnd.qx      = x0[CW-1:0];
    bnd.qz      = z0[CW-1:0];
  end

endmodule

// File: design/nbr_seq.sv
// Sequencer: walks cells and bitmap bytes through the two RAM ports.
`timescale 1ns / 1ps
module nbr_seq import nbr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  req_t       req,
  input  logic [8:0] grid_width,
  input  logic [8:0] grid_depth,
  input  logic [7:0] extend,
  input  logic       res_free,
  output logic       idle,
  output logic       res_valid,
  output res_t       res,
  output hreq_t      h_req,
  input  logic [7:0] h_rdata,
  output wreq_t      w_req,
  input  logic [7:0] w_rdata
);

  state_t        state, state_next;
  req_t          req_r;
  bnd_t          bnd, bnd_c;
  logic [CW-1:0] w_eff, d_eff;
  logic [CW-1:0] cx, cz, bx_last;
  logic [HA-1:0] cnt;
  logic          p_valid;
  logic [CW-1:0] p_x, p_z;
  logic [7:0]    acc, acc_next;
  logic          p_bit;
  logic          walk_r, done_r;
  logic          box_last, blit_last, build_last, sweep_last;
  logic [7:0]    bmask;
  logic [CW+2:0] bpos;

  assign w_eff = (32'(grid_width) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(grid_width);
  assign d_eff = (32'(grid_depth) > MAX_DEPTH) ? CW'(MAX_DEPTH) : CW'(grid_depth);

  nbr_bounds u_bounds (
    .req    (req_r),
    .w_eff  (w_eff),
    .d_eff  (d_eff),
    .extend (extend),
    .bnd    (bnd_c)
  );

  assign sweep_last = (cnt == HA'(H_DEPTH - 1));
  assign box_last   = (CW'(cx + 1'b1) >= bnd.x_hi) && (CW'(cz + 1'b1) >= bnd.z_hi);
  assign blit_last  = (cx == bx_last) && (CW'(cz + 1'b1) >= bnd.z_hi);
  assign build_last = (cx == CW'(MAX_WIDTH - 1)) && (cz == CW'(MAX_DEPTH - 1));

  // bit mask of the rectangle within the current bitmap byte
  always_comb begin
    bmask = '0;
    bpos  = '0;
    for (int k = 0; k < 8; k++) begin
      bpos     = {cx, 3'(k)};
      bmask[k] = (bpos >= (CW + 3)'(bnd.x_lo)) && (bpos < (CW + 3)'(bnd.x_hi));
    end
  end

  // build pipeline: the height read on the previous cycle lands in the byte accumulator
  always_comb begin
    p_bit    = (h_rdata >= 8'(WALK_MIN)) && (h_rdata <= 8'(WALK_MAX)) &&
               (p_x < w_eff) && (p_z < d_eff);
    acc_next = ((p_x[2:0] == 3'd0) ? 8'b0 : acc) | (8'(p_bit) << p_x[2:0]);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:       if (sweep_last) state_next = S_IDLE;
      S_IDLE:       if (accept) state_next = S_SETUP;
      S_SETUP: begin
        unique case (req_r.operation)
          OP_CLEAR: state_next = S_CLEAR;
          OP_BOX:   state_next = (bnd_c.box_hit && !bnd_c.empty) ? S_BOX_RD : S_DONE;
          OP_BUILD: state_next = S_BUILD;
          OP_BLIT:  state_next = bnd_c.empty ? S_DONE : S_BLIT_RD;
          OP_QUERY: state_next = bnd_c.in_grid ? S_QUERY_RD : S_DONE;
          default:  state_next = S_DONE;
        endcase
      end
      S_CLEAR:      if (sweep_last) state_next = S_DONE;
      S_BOX_RD:     state_next = S_BOX_WR;
      S_BOX_WR:     state_next = box_last ? S_DONE : S_BOX_RD;
      S_BUILD:      if (build_last) state_next = S_BUILD_END;
      S_BUILD_END:  state_next = S_DONE;
      S_BLIT_RD:    state_next = S_BLIT_WR;
      S_BLIT_WR:    state_next = blit_last ? S_DONE : S_BLIT_RD;
      S_QUERY_RD:   state_next = S_QUERY_WAIT;
      S_QUERY_WAIT: state_next = S_DONE;
      S_DONE:       if (res_free) state_next = S_IDLE;
      default:      state_next = S_INIT;
    endcase
  end

  always_comb begin
    idle          = (state == S_IDLE);
    res_valid     = (state == S_DONE) && res_free;
    res.walkable  = walk_r;
    res.op_done   = done_r;
    h_req.we      = 1'b0;
    h_req.waddr   = HA'(cz) * HA'(MAX_WIDTH) + HA'(cx);
    h_req.wdata   = bnd.top;
    h_req.raddr   = HA'(cz) * HA'(MAX_WIDTH) + HA'(cx);
    w_req.we      = 1'b0;
    w_req.waddr   = WA'(cz) * WA'(LINE_BYTES) + WA'(cx);
    w_req.wdata   = req_r.fill_value ? (w_rdata | bmask) : (w_rdata & ~bmask);
    w_req.raddr   = WA'(cz) * WA'(LINE_BYTES) + WA'(cx);
    unique case (state)
      S_INIT: begin
        h_req.we    = 1'b1;
        h_req.waddr = cnt;
        h_req.wdata = '0;
        w_req.we    = (32'(cnt) < W_DEPTH);
        w_req.waddr = cnt[WA-1:0];
        w_req.wdata = '0;
      end
      S_CLEAR: begin
        h_req.we    = 1'b1;
        h_req.waddr = cnt;
        h_req.wdata = '0;
      end
      S_BOX_WR: h_req.we = (h_rdata < bnd.top);
      S_BUILD, S_BUILD_END: begin
        w_req.we    = p_valid && ((p_x[2:0] == 3'(BIT_MASK)) ||
                                  (p_x == CW'(MAX_WIDTH - 1)));
        w_req.waddr = WA'(p_z) * WA'(LINE_BYTES) + WA'(p_x >> 3);
        w_req.wdata = acc_next;
      end
      S_BLIT_WR: w_req.we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      cnt     <= '0;
      p_valid <= 1'b0;
    end else begin
      state   <= state_next;
      p_valid <= (state == S_BUILD);
      if (state == S_INIT || state == S_CLEAR) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_x <= cx;
    p_z <= cz;
    if (p_valid) begin
      acc <= acc_next;
    end
    unique case (state)
      S_IDLE: if (accept) req_r <= req;
      S_SETUP: begin
        bnd     <= bnd_c;
        walk_r  <= 1'b0;
        done_r  <= (req_r.operation <= OP_QUERY);
        bx_last <= CW'((bnd_c.x_hi - 1'b1) >> 3);
        unique case (req_r.operation)
          OP_BOX: begin
            cx <= bnd_c.x_lo;
            cz <= bnd_c.z_lo;
          end
          OP_BLIT: begin
            cx <= bnd_c.x_lo >> 3;
            cz <= bnd_c.z_lo;
          end
          OP_QUERY: begin
            cx <= bnd_c.qx >> 3;
            cz <= bnd_c.qz;
          end
          default: begin
            cx <= '0;
            cz <= '0;
          end
        endcase
      end
      S_BOX_WR: begin
        if (CW'(cx + 1'b1) < bnd.x_hi) begin
          cx <= cx + 1'b1;
        end else begin
          cx <= bnd.x_lo;
          cz <= cz + 1'b1;
        end
      end
      S_BLIT_WR: begin
        if (cx != bx_last) begin
          cx <= cx + 1'b1;
        end else begin
          cx <= bnd.x_lo >> 3;
          cz <= cz + 1'b1;
        end
      end
      S_BUILD: begin
        if (cx == CW'(MAX_WIDTH - 1)) begin
          cx <= '0;
          cz <= cz + 1'b1;
        end else begin
          cx <= cx + 1'b1;
        end
      end
      S_QUERY_WAIT: walk_r <= w_rdata[bnd.qx[2:0]];
      default: ;
    endcase
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !h_req.we && !w_req.we)
    else $error("RAM write while idle");

  a_box_pairs: assert property (@(posedge clk) disable iff (rst)
    state == S_BOX_WR |-> $past(state) == S_BOX_RD)
    else $error("box write without preceding read");

  a_build_flush: assert property (@(posedge clk) disable iff (rst)
    state == S_BUILD_END |=> state == S_DONE)
    else $error("build flush did not finish");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |-> state == S_IDLE)
    else $error("request accepted while busy");

endmodule

// File: design/nav_bitmap_rasterizer_unit.sv
// Top level of the navigation bitmap rasterizer: ports, config, result register.
`timescale 1ns / 1ps
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  in       | in_valid/in_stall  | in_data  (req_t: operation, box, fill)
//  out      | out_valid/out_stall| out_data (res_t: walkable, op_done)
//  cfg      | cfg_valid/cfg_ready| cfg_index, cfg_data (width, depth, extend)
//
//  After reset a clearing pass writes zero to every height cell and bitmap
//  byte; requests are stalled meanwhile (config is still taken).
//  One request at a time through a single sequencer over both RAM ports:
//  clear zeroes every height cell, build visits every cell, box reads and
//  writes each covered cell, blit each touched byte per row, query reads
//  one bitmap byte unless off the grid; unknown codes touch no RAM.
//  A finished result waits in the output register; the next request is
//  taken at once, and its result holds until the register frees.
module nav_bitmap_rasterizer_unit import nbr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  req_t       in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output res_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  logic [8:0] grid_width;
  logic [8:0] grid_depth;
  logic [7:0] extend;
  logic       idle, accept, res_valid, res_free;
  res_t       res;
  hreq_t      h_req;
  wreq_t      w_req;
  logic [7:0] h_rdata, w_rdata;

  // config writes always land; the user must issue them only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= 9'd256;
      grid_depth <= 9'd256;
      extend     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIDTH:  grid_width <= cfg_data;
        CFG_DEPTH:  grid_depth <= cfg_data;
        CFG_EXTEND: extend     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // hold requests off whenever the sequencer is busy
  assign in_stall = !idle;
  assign accept   = in_valid && !in_stall;
  // result register frees when empty or drained this cycle
  assign res_free = !out_valid || !out_stall;

  nbr_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .req        (in_data),
    .grid_width (grid_width),
    .grid_depth (grid_depth),
    .extend     (extend),
    .res_free   (res_free),
    .idle       (idle),
    .res_valid  (res_valid),
    .res        (res),
    .h_req      (h_req),
    .h_rdata    (h_rdata),
    .w_req      (w_req),
    .w_rdata    (w_rdata)
  );

  // height map: one byte per cell
  nbr_ram #(.WIDTH(8), .DEPTH(H_DEPTH)) u_height (
    .clk   (clk),
    .we    (h_req.we),
    .waddr (h_req.waddr),
    .wdata (h_req.wdata),
    .raddr (h_req.raddr),
    .rdata (h_rdata)
  );

  // walk bitmap: eight cells per byte
  nbr_ram #(.WIDTH(8), .DEPTH(W_DEPTH)) u_walk (
    .clk   (clk),
    .we    (w_req.we),
    .waddr (w_req.waddr),
    .wdata (w_req.wdata),
    .raddr (w_req.raddr),
    .rdata (w_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !out_valid || !out_stall)
    else $error("result overwrote a held result");

endmodule
